### rtl/lpkm_pkg.sv
// Shared types and constants for the linear probe key index map.
package lpkm_pkg;

  localparam int KEY_W      = 48;
  localparam int VALUE_W    = 16;
  localparam int FILL_W     = 7;
  localparam int FILL_RESET = 45;

  typedef enum logic {
    CMD_FIND   = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADKEY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DONE
  } state_t;

  // write strobes from the sequencer to the slot store
  typedef struct packed {
    logic key_we;
    logic val_we;
  } wr_t;

  // sequencer status seen by the top level checks
  typedef struct packed {
    logic clearing;
    logic probing;
    logic done;
  } ctrl_stat_t;

endpackage

### rtl/lpkm_if.sv
// Valid/ready channel interfaces for request and result words.
interface lpkm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [lpkm_pkg::KEY_W-1:0]   key;
  logic [lpkm_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, cmd, key, value_in, input ready);
  modport sink   (input valid, cmd, key, value_in, output ready);
endinterface

interface lpkm_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [lpkm_pkg::VALUE_W-1:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

### rtl/lpkm_slot_store.sv
// Slot store: key memory and value memory, one write and one registered read per cycle.
module lpkm_slot_store #(
  parameter int SLOT_COUNT = 64,
  parameter int VAL_W      = 16,
  localparam int SLOT_BITS = $clog2(SLOT_COUNT)
) (
  input  logic                       clk,
  input  logic [SLOT_BITS-1:0]       rd_addr,
  input  lpkm_pkg::wr_t              wr,
  input  logic [SLOT_BITS-1:0]       wr_addr,
  input  logic [lpkm_pkg::KEY_W-1:0] wr_key,
  input  logic [VAL_W-1:0]           wr_val,
  output logic [lpkm_pkg::KEY_W-1:0] rd_key,
  output logic [VAL_W-1:0]           rd_val
);

  logic [lpkm_pkg::KEY_W-1:0] key_mem [SLOT_COUNT];
  logic [VAL_W-1:0]           val_mem [SLOT_COUNT];
  logic [lpkm_pkg::KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0]           rd_val_r;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_val_r <= val_mem[rd_addr];
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

### rtl/lpkm_ctrl.sv
// Probe sequencer: hashing, slot walk, entry count, fill limit and result register.
module lpkm_ctrl #(
  parameter int SLOT_COUNT = 64,
  parameter int VAL_W      = 16,
  localparam int SLOT_BITS = $clog2(SLOT_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lpkm_in_if.sink                       in_ch,
  lpkm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lpkm_pkg::FILL_W-1:0]   cfg_wdata,
  output logic [SLOT_BITS-1:0]          rd_addr,
  output lpkm_pkg::wr_t                 wr,
  output logic [SLOT_BITS-1:0]          wr_addr,
  output logic [lpkm_pkg::KEY_W-1:0]    wr_key,
  output logic [VAL_W-1:0]              wr_val,
  input  logic [lpkm_pkg::KEY_W-1:0]    rd_key,
  input  logic [VAL_W-1:0]              rd_val,
  output lpkm_pkg::ctrl_stat_t          stat
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = (CNT_W > lpkm_pkg::FILL_W) ? CNT_W : lpkm_pkg::FILL_W;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);
  localparam logic [SLOT_BITS:0]   SLOTS_EXT = (SLOT_BITS + 1)'(SLOT_COUNT);
  localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(SLOT_COUNT);

  // xor-fold the key into slot bits, then one conditional subtract
  function automatic logic [SLOT_BITS-1:0] home_of(input logic [lpkm_pkg::KEY_W-1:0] k);
    logic [SLOT_BITS-1:0] f;
    logic [SLOT_BITS:0]   e;
    f = '0;
    for (int i = 0; i < lpkm_pkg::KEY_W; i++) begin
      f[i % SLOT_BITS] = f[i % SLOT_BITS] ^ k[i];
    end
    e = {1'b0, f};
    if (e >= SLOTS_EXT) begin
      e = e - SLOTS_EXT;
    end
    return e[SLOT_BITS-1:0];
  endfunction

  lpkm_pkg::state_t state_r, state_nxt;

  logic [SLOT_BITS-1:0]          clr_r, clr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [lpkm_pkg::FILL_W-1:0]   fill_r;
  lpkm_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [lpkm_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]              val_r, val_nxt;
  logic [SLOT_BITS-1:0]          s_r, s_nxt;
  logic [SLOT_BITS-1:0]          n_r, n_nxt;
  lpkm_pkg::status_t             res_status_r, res_status_nxt;
  logic [lpkm_pkg::VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [lpkm_pkg::VALUE_W-1:0]  out_value_r, out_value_nxt;

  logic [SLOT_BITS-1:0] in_home;
  logic [SLOT_BITS-1:0] s_next;
  logic                 tbl_full;

  assign in_home  = home_of(in_ch.key);
  assign s_next   = (s_r == LAST_SLOT) ? '0 : s_r + 1'b1;
  assign tbl_full = (CMP_W'(cnt_r) >= CMP_W'(fill_r)) || (cnt_r == CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpkm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      cnt_r       <= '0;
      fill_r      <= lpkm_pkg::FILL_W'(lpkm_pkg::FILL_RESET);
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    s_r          <= s_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    s_nxt          = s_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    in_ch.ready    = 1'b0;
    rd_addr        = in_home;
    wr             = '0;
    wr_addr        = s_r;
    wr_key         = key_r;
    wr_val         = val_r;
    stat           = '0;

    unique case (state_r)
      lpkm_pkg::ST_CLEAR: begin
        // empty every key slot after reset
        stat.clearing = 1'b1;
        wr.key_we     = 1'b1;
        wr_addr       = clr_r;
        wr_key        = '0;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          clr_nxt   = '0;
          state_nxt = lpkm_pkg::ST_IDLE;
        end
      end

      lpkm_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt       = lpkm_pkg::cmd_t'(in_ch.cmd);
          key_nxt       = in_ch.key;
          val_nxt       = in_ch.value_in[VAL_W-1:0];
          s_nxt         = in_home;
          n_nxt         = '0;
          res_value_nxt = '0;
          if (in_ch.key == '0) begin
            res_status_nxt = lpkm_pkg::STAT_BADKEY;
            state_nxt      = lpkm_pkg::ST_DONE;
          end else if (lpkm_pkg::cmd_t'(in_ch.cmd) == lpkm_pkg::CMD_INSERT && tbl_full) begin
            res_status_nxt = lpkm_pkg::STAT_FULL;
            state_nxt      = lpkm_pkg::ST_DONE;
          end else begin
            // status if the walk runs out of slots
            res_status_nxt = (lpkm_pkg::cmd_t'(in_ch.cmd) == lpkm_pkg::CMD_FIND) ?
                             lpkm_pkg::STAT_MISS : lpkm_pkg::STAT_FULL;
            state_nxt      = lpkm_pkg::ST_CHECK;
          end
        end
      end

      lpkm_pkg::ST_CHECK: begin
        // rd_key/rd_val hold slot s_r
        stat.probing = 1'b1;
        rd_addr      = s_next;
        if (cmd_r == lpkm_pkg::CMD_FIND && rd_key == key_r) begin
          res_status_nxt = lpkm_pkg::STAT_HIT;
          res_value_nxt  = lpkm_pkg::VALUE_W'(rd_val);
          state_nxt      = lpkm_pkg::ST_DONE;
        end else if (rd_key == '0) begin
          if (cmd_r == lpkm_pkg::CMD_INSERT) begin
            wr.key_we      = 1'b1;
            wr.val_we      = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            res_status_nxt = lpkm_pkg::STAT_HIT;
          end
          state_nxt = lpkm_pkg::ST_DONE;
        end else if (n_r == LAST_SLOT) begin
          state_nxt = lpkm_pkg::ST_DONE;
        end else begin
          s_nxt = s_next;
          n_nxt = n_r + 1'b1;
        end
      end

      lpkm_pkg::ST_DONE: begin
        stat.done = 1'b1;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = lpkm_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = out_value_r;

endmodule

### rtl/linear_probe_key_index_map_unit.sv
// Top level of the linear probe key index map: sequencer, slot store and checks.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        cmd, key[47:0], value_in[15:0]
//  out_ch   out  valid/ready        status[1:0], value_out[15:0]
//  cfg      in   cfg_we             cfg_wdata[6:0] -> fill_limit
//
// A request probes P slots (1..SLOT_COUNT): the accept cycle reads the home
// slot, one slot is compared per cycle, then the result word is loaded once
// out_ch has room. Key zero and refused inserts skip the walk; one request in
// flight. After rst_n is released a clearing pass empties the key memory with
// in_ch.ready low. A result word waiting on out_ch does not block the next
// accept; a second finished result waits until it is taken.
module linear_probe_key_index_map_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpkm_in_if.sink                     in_ch,
  lpkm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [lpkm_pkg::FILL_W-1:0] cfg_wdata
);

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int VAL_W = (INDEX_BITS < lpkm_pkg::VALUE_W) ? INDEX_BITS : lpkm_pkg::VALUE_W;

  logic [SLOT_BITS-1:0]       rd_addr;
  logic [SLOT_BITS-1:0]       wr_addr;
  lpkm_pkg::wr_t              wr;
  logic [lpkm_pkg::KEY_W-1:0] wr_key;
  logic [VAL_W-1:0]           wr_val;
  logic [lpkm_pkg::KEY_W-1:0] rd_key;
  logic [VAL_W-1:0]           rd_val;
  lpkm_pkg::ctrl_stat_t       stat;

  lpkm_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .VAL_W      (VAL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_val    (wr_val),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .stat      (stat)
  );

  lpkm_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .VAL_W      (VAL_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  // no request is taken while the key memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ch.ready)
    else $error("request accepted during clearing pass");

  // one request at a time: an accept is followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request accepted while one is in flight");

  // only a find hit carries a nonzero index
  a_value_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.value_out != '0) |-> (out_ch.status == lpkm_pkg::STAT_HIT))
    else $error("nonzero value_out without hit status");

  // a new result word comes only from the done step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(stat.done))
    else $error("result word loaded outside the done step");

  // a slot write happens only while clearing or probing
  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.key_we || wr.val_we) |-> (stat.clearing || stat.probing))
    else $error("slot write outside clearing or probing");

endmodule
